// ===== rtl/mtc_qf_pkg.sv =====
`default_nettype none

package mtc_qf_pkg;

  // Input item codes
  typedef enum logic [1:0] {
    OP_QF   = 2'd0,
    OP_FULL = 2'd1,
    OP_TICK = 2'd2,
    OP_DISC = 2'd3
  } op_e;

  // Result item codes
  typedef enum logic [1:0] {
    EV_QF_TIME   = 2'd0,
    EV_FF_TIME   = 2'd1,
    EV_STARTED   = 2'd2,
    EV_STOPPED   = 2'd3
  } ev_e;

  // Register map
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_IDX_TIMEOUT = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // Quarter-frame sequence
  localparam logic [2:0] FIRST_PIECE = 3'd0;
  localparam logic [2:0] LAST_PIECE  = 3'd7;

  // Time limits
  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [5:0] SIXTY         = 6'd60;

  // Result queue geometry
  localparam int unsigned RES_Q_DEPTH = 4;
  localparam int unsigned RES_Q_AW    = 2;
  localparam int unsigned RES_Q_CW    = 3;

  typedef struct packed {
    op_e        op;
    logic [2:0] piece;
    logic [3:0] nibble;
    logic [4:0] hours_in;
    logic [5:0] minutes_in;
    logic [5:0] seconds_in;
    logic [4:0] frames_in;
    logic [1:0] rate_in;
  } in_t;

  typedef struct packed {
    ev_e        event_res;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] frames;
    logic [1:0] rate;
    logic       last;
  } out_t;

  // Results of one item handed from the core to the queue
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } res_t;

  // Queue status back to the top level
  typedef struct packed {
    logic [RES_Q_CW-1:0] count;
    logic                room;
  } q_stat_t;

  // Nominal frames per second by rate code
  function automatic logic [4:0] nominal_fps(input logic [1:0] rate);
    logic [4:0] fps;
    case (rate)
      2'd0:    fps = 5'd24;
      2'd1:    fps = 5'd25;
      default: fps = 5'd30;
    endcase
    return fps;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mtc_qf_core.sv =====
`default_nettype none

module mtc_qf_core import mtc_qf_pkg::*; #(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire in_t         item_i,
  input  wire logic [15:0] timeout_i,
  output res_t             res_o
);

  localparam int unsigned CW = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;

  logic [3:0]              store_q [0:6];
  logic [2:0]              count_q, count_d;
  logic [ELAPSED_BITS-1:0] ticks_q, ticks_d, ticks_inc;
  logic                    playing_q, playing_d;
  logic                    store_we;
  logic                    gap;
  logic [2:0]              pc_eff;
  logic                    qf_take;
  logic [4:0]              qf_h, qf_f;
  logic [5:0]              qf_m, qf_s;
  logic [1:0]              qf_r;
  logic [1:0]              n;
  out_t                    r0, r1;

  function automatic logic time_ok(input logic [4:0] h, input logic [5:0] m,
                                   input logic [5:0] s, input logic [4:0] f,
                                   input logic [1:0] r);
    return (h < HOURS_PER_DAY) && (m < SIXTY) && (s < SIXTY) && (f < nominal_fps(r));
  endfunction

  function automatic out_t make_res(input ev_e ev, input logic [4:0] h,
                                    input logic [5:0] m, input logic [5:0] s,
                                    input logic [4:0] f, input logic [1:0] r);
    out_t o;
    o.event_res = ev;
    o.hours     = h;
    o.minutes   = m;
    o.seconds   = s;
    o.frames    = f;
    o.rate      = r;
    o.last      = 1'b0;
    return o;
  endfunction

  // Gap check and piece sequencing
  assign gap     = CW'(ticks_q) > CW'(timeout_i);
  assign pc_eff  = gap ? FIRST_PIECE : count_q;
  assign qf_take = (item_i.piece == pc_eff) || (item_i.piece == FIRST_PIECE);

  // Assembled time; piece 7 comes straight from the current item
  assign qf_f = {store_q[1][0], store_q[0]};
  assign qf_s = {store_q[3][1:0], store_q[2]};
  assign qf_m = {store_q[5][1:0], store_q[4]};
  assign qf_h = {item_i.nibble[0], store_q[6]};
  assign qf_r = item_i.nibble[2:1];

  assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;

  // Event decode and next state
  always_comb begin
    count_d   = count_q;
    ticks_d   = ticks_q;
    playing_d = playing_q;
    store_we  = 1'b0;
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    case (item_i.op)
      OP_QF: begin
        ticks_d = '0;
        if (!qf_take) begin
          count_d = FIRST_PIECE;
        end else if (item_i.piece != LAST_PIECE) begin
          count_d  = item_i.piece + 3'd1;
          store_we = 1'b1;
        end else begin
          count_d = FIRST_PIECE;
          if (time_ok(qf_h, qf_m, qf_s, qf_f, qf_r)) begin
            r0 = make_res(EV_QF_TIME, qf_h, qf_m, qf_s, qf_f, qf_r);
            n  = 2'd1;
            if (!playing_q) begin
              playing_d = 1'b1;
              r1 = make_res(EV_STARTED, '0, '0, '0, '0, '0);
              n  = 2'd2;
            end
          end
        end
      end
      OP_FULL: begin
        if (time_ok(item_i.hours_in, item_i.minutes_in, item_i.seconds_in,
                    item_i.frames_in, item_i.rate_in)) begin
          count_d = FIRST_PIECE;
          r0 = make_res(EV_FF_TIME, item_i.hours_in, item_i.minutes_in,
                        item_i.seconds_in, item_i.frames_in, item_i.rate_in);
          n  = 2'd1;
        end
      end
      OP_TICK: begin
        ticks_d = ticks_inc;
        if (playing_q && (CW'(ticks_inc) >= CW'(timeout_i))) begin
          playing_d = 1'b0;
          r0 = make_res(EV_STOPPED, '0, '0, '0, '0, '0);
          n  = 2'd1;
        end
      end
      OP_DISC: begin
        playing_d = 1'b0;
        count_d   = FIRST_PIECE;
        if (playing_q) begin
          r0 = make_res(EV_STOPPED, '0, '0, '0, '0, '0);
          n  = 2'd1;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
    r0.last = (n == 2'd1);
    r1.last = (n == 2'd2);
  end

  assign res_o.n  = fire_i ? n : 2'd0;
  assign res_o.r0 = r0;
  assign res_o.r1 = r1;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= FIRST_PIECE;
      ticks_q   <= '1;
      playing_q <= 1'b0;
    end else if (fire_i) begin
      count_q   <= count_d;
      ticks_q   <= ticks_d;
      playing_q <= playing_d;
    end
  end

  // Piece store, no reset
  always_ff @(posedge clk_i) begin
    if (fire_i && store_we) begin
      store_q[item_i.piece] <= item_i.nibble;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtc_qf_res_q.sv =====
`default_nettype none

module mtc_qf_res_q import mtc_qf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire res_t push_i,
  input  wire logic pop_i,
  output out_t      data_o,
  output q_stat_t   stat_o
);

  out_t                mem_q [0:RES_Q_DEPTH-1];
  logic [RES_Q_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [RES_Q_CW-1:0] count_q;

  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_Q_AW'(push_i.n);
      rd_ptr_q <= rd_ptr_q + RES_Q_AW'(pop_i);
      count_q  <= count_q + RES_Q_CW'(push_i.n) - RES_Q_CW'(pop_i);
    end
  end

  // Storage: up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.room  = count_q <= RES_Q_CW'(RES_Q_DEPTH - 2);

endmodule

`default_nettype wire

// ===== rtl/midi_timecode_quarter_frame_decoder.sv =====
// MIDI time code quarter-frame decoder.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one event per
// item: quarter-frame piece, full frame, millisecond tick or disconnect.
// Output channel (out_valid_o / out_stall_i / out_data_o) carries decoded
// times and started/stopped reports; an item causes zero, one or two results,
// and "last" marks the final one of each item.
// An accepted item is held in the input register until the result queue has
// room, is then decoded and its results land in a four-entry result queue,
// which offers them on the output. One item is accepted every cycle while
// the queue has room for two results; the output drains one result per cycle
// while the receiver does not stall, so an item that causes two results is
// drained as two separate results.
// When the receiver stalls, results wait in the queue and the input stalls
// once fewer than two queue entries are free.
// timeout_ticks is written over the APB port at byte address 0 (reset 500).
// Reset empties the queue, clears the piece count and playing flag and
// saturates the tick counter; the piece store is not cleared.
`default_nettype none

module midi_timecode_quarter_frame_decoder import mtc_qf_pkg::*; #(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_t                    out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic        in_vld_q, in_vld_d;
  in_t         in_q;
  logic        load, fire, pop;
  logic [15:0] timeout_q;
  res_t        res;
  q_stat_t     stat;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_IDX_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1] == REG_IDX_TIMEOUT)) begin
      timeout_q <= pwdata[15:0];
    end
  end

  // Input register
  assign fire       = in_vld_q && stat.room;
  assign in_stall_o = in_vld_q && !stat.room;
  assign load       = in_valid_i && !in_stall_o;
  assign in_vld_d   = load ? 1'b1 : (fire ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_q <= in_data_i;
    end
  end

  // Event decoder
  mtc_qf_core #(
    .ELAPSED_BITS(ELAPSED_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_q),
    .timeout_i (timeout_q),
    .res_o     (res)
  );

  // Result queue
  assign out_valid_o = stat.count != '0;
  assign pop         = out_valid_o && !out_stall_i;

  mtc_qf_res_q u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res),
    .pop_i  (pop),
    .data_o (out_data_o),
    .stat_o (stat)
  );

`ifndef SYNTHESIS
  a_q_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= RES_Q_CW'(RES_Q_DEPTH))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.n != 2'd0) |=> out_valid_o)
    else $error("pushed result not offered");

  a_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(in_q)))
    else $error("blocked item lost");
`endif

endmodule

`default_nettype wire
